// File: rtl/csbp_pkg.sv
// Shared types, constants and helper functions for the constellation slicer and bit packer.
// No dependencies; every other file of the block imports this package.
package csbp_pkg;

    // Field widths of the symbol, the points and the packed byte.
    localparam int LANES       = 16;
    localparam int COORD_W     = 10;
    localparam int POINT_W     = 2 * COORD_W;
    localparam int SQ_W        = 2 * COORD_W;
    localparam int DIST_W      = SQ_W + 1;
    localparam int IDX_W       = 4;
    localparam int VAL_W       = 4;
    localparam int BYTE_W      = 8;
    localparam int OFF_W       = 4;
    localparam int RES_CNT_W   = 3;
    localparam int COUNT_W     = 5;
    localparam int NBITS_W     = 3;
    localparam int GROUPS      = LANES / 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int SLOTS_PER_REG = 3;

    localparam int DEFAULT_MAX_POINTS = 16;

    localparam logic [COUNT_W-1:0] POINT_COUNT_RESET = COUNT_W'(4);
    localparam logic [COUNT_W-1:0] MIN_POINTS        = COUNT_W'(2);
    localparam logic [OFF_W-1:0]   OFFSET_FULL       = OFF_W'(BYTE_W);
    localparam logic [DIST_W-1:0]  DIST_UNUSED       = '1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POINT_COUNT = 3'd0,
        REG_POINTS_0    = 3'd1,
        REG_POINTS_3    = 3'd2,
        REG_POINTS_6    = 3'd3,
        REG_POINTS_9    = 3'd4,
        REG_POINTS_12   = 3'd5,
        REG_POINT_15    = 3'd6,
        REG_VALUE_TABLE = 3'd7
    } cfg_index_e;

    // Decoded configuration seen by the datapath.
    typedef struct packed {
        logic [COUNT_W-1:0]              active_count;
        logic [NBITS_W-1:0]              nbits;
        logic [LANES-1:0][POINT_W-1:0]   points;
        logic [LANES*VAL_W-1:0]          value_table;
    } cfg_t;

    // Distance stage: one squared distance per point slot.
    typedef struct packed {
        logic                            valid;
        logic                            frame_start;
        logic [LANES-1:0][DIST_W-1:0]    metric;
    } dist_stage_t;

    // One candidate of the nearest-point search.
    typedef struct packed {
        logic [DIST_W-1:0] metric;
        logic [IDX_W-1:0]  idx;
    } cand_t;

    // Group stage: the winner of each group of four points.
    typedef struct packed {
        logic                     valid;
        logic                     frame_start;
        logic [GROUPS-1:0][DIST_W+IDX_W-1:0] cand;
    } grp_stage_t;

    // Symbol stage: the bit value of the nearest point.
    typedef struct packed {
        logic             valid;
        logic             frame_start;
        logic [VAL_W-1:0] value;
    } sym_stage_t;

    // Point count saturated into the supported range.
    function automatic logic [COUNT_W-1:0] active_points(
        input logic [COUNT_W-1:0] count,
        input logic [COUNT_W-1:0] max_points
    );
        logic [COUNT_W-1:0] p;
        p = count;
        if (p < MIN_POINTS)
        begin
            p = MIN_POINTS;
        end
        if (p > max_points)
        begin
            p = max_points;
        end
        return p;
    endfunction

    // Bits per symbol for a point count: ceil(log2(p)).
    function automatic logic [NBITS_W-1:0] bits_for(input logic [COUNT_W-1:0] p);
        logic [NBITS_W-1:0] n;
        if (p <= COUNT_W'(2))
        begin
            n = NBITS_W'(1);
        end
        else if (p <= COUNT_W'(4))
        begin
            n = NBITS_W'(2);
        end
        else if (p <= COUNT_W'(8))
        begin
            n = NBITS_W'(3);
        end
        else
        begin
            n = NBITS_W'(4);
        end
        return n;
    endfunction

    // Mask that keeps the low nbits of a table entry.
    function automatic logic [VAL_W-1:0] value_mask(input logic [NBITS_W-1:0] nbits);
        logic [VAL_W-1:0] m;
        case (nbits)
            NBITS_W'(1): m = 4'b0001;
            NBITS_W'(2): m = 4'b0011;
            NBITS_W'(3): m = 4'b0111;
            default:     m = 4'b1111;
        endcase
        return m;
    endfunction

endpackage

// File: rtl/csbp_if.sv
// Valid/ready channel interfaces for symbols, packed bytes and configuration writes.
// Depends on csbp_pkg for field widths.

// Symbol channel: one equalized symbol or a frame-start mark per request.
interface csbp_sym_if;
    import csbp_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      frame_start;
    logic signed [COORD_W-1:0] sym_i;
    logic signed [COORD_W-1:0] sym_q;

    modport source (output valid, output frame_start, output sym_i, output sym_q,
                    input ready);
    modport sink   (input valid, input frame_start, input sym_i, input sym_q,
                    output ready);
endinterface

// Byte channel: one completed byte per request.
interface csbp_byte_if;
    import csbp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

// Configuration write channel: register index and write data.
interface csbp_cfg_if;
    import csbp_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/csbp_cfg_regs.sv
// Configuration register file: point count, sixteen constellation points and the value table.
// Depends on csbp_pkg and the csbp_cfg_if interface.
module csbp_cfg_regs #(
    parameter int MaxPoints = csbp_pkg::DEFAULT_MAX_POINTS
) (
    input  logic              clk,
    input  logic              rst_n,
    csbp_cfg_if.sink          cfg,
    output csbp_pkg::cfg_t    cfg_out
);
    import csbp_pkg::*;

    logic [COUNT_W-1:0]            point_count_reg;
    logic [LANES-1:0][POINT_W-1:0] points_reg;
    logic [LANES*VAL_W-1:0]        value_table_reg;
    logic [IDX_W-1:0]              slot_base;
    logic [COUNT_W-1:0]            active_count;

    // Writes never stall.
    assign cfg.ready = 1'b1;

    // First point slot covered by a three-point register.
    always_comb
    begin
        slot_base = IDX_W'(({1'b0, cfg.index} - 4'd1) * 4'd3);
    end

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= POINT_COUNT_RESET;
            points_reg      <= '0;
            value_table_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg_index_e'(cfg.index))
                REG_POINT_COUNT:
                begin
                    point_count_reg <= cfg.data[COUNT_W-1:0];
                end
                REG_POINTS_0, REG_POINTS_3, REG_POINTS_6, REG_POINTS_9, REG_POINTS_12:
                begin
                    for (int s = 0; s < SLOTS_PER_REG; s++)
                    begin
                        points_reg[slot_base + IDX_W'(s)] <= cfg.data[POINT_W*s +: POINT_W];
                    end
                end
                REG_POINT_15:
                begin
                    points_reg[LANES-1] <= cfg.data[POINT_W-1:0];
                end
                REG_VALUE_TABLE:
                begin
                    value_table_reg <= cfg.data[LANES*VAL_W-1:0];
                end
                default:
                begin
                    point_count_reg <= point_count_reg;
                end
            endcase
        end
    end

    // Decoded view for the datapath.
    always_comb
    begin
        active_count        = active_points(point_count_reg, COUNT_W'(MaxPoints));
        cfg_out.active_count = active_count;
        cfg_out.nbits        = bits_for(active_count);
        cfg_out.points       = points_reg;
        cfg_out.value_table  = value_table_reg;
    end

endmodule

// File: rtl/csbp_dist.sv
// Input register and squared-distance lanes, one lane per constellation point.
// Depends on csbp_pkg.
module csbp_dist #(
    parameter int MaxPoints = csbp_pkg::DEFAULT_MAX_POINTS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             advance,
    input  logic                             in_valid,
    input  logic                             in_frame_start,
    input  logic signed [csbp_pkg::COORD_W-1:0] in_sym_i,
    input  logic signed [csbp_pkg::COORD_W-1:0] in_sym_q,
    input  csbp_pkg::cfg_t                   cfg,
    output csbp_pkg::dist_stage_t            dist_out
);
    import csbp_pkg::*;

    logic                      s1_valid_reg;
    logic                      s1_frame_reg;
    logic signed [COORD_W-1:0] s1_i_reg;
    logic signed [COORD_W-1:0] s1_q_reg;
    logic [LANES-1:0][DIST_W-1:0] dist_next;
    logic                      s2_valid_reg;
    logic                      s2_frame_reg;
    logic [LANES-1:0][DIST_W-1:0] s2_dist_reg;

    // Valid bits of the input and distance registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Payload registers of both stages.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_frame_reg <= in_frame_start;
            s1_i_reg     <= in_sym_i;
            s1_q_reg     <= in_sym_q;
            s2_frame_reg <= s1_frame_reg;
            s2_dist_reg  <= dist_next;
        end
    end

    // One lane per supported point; slots past the active count never win.
    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        if (k < MaxPoints)
        begin : g_used
            logic signed [COORD_W:0]     di;
            logic signed [COORD_W:0]     dq;
            logic signed [2*COORD_W+1:0] di_sq;
            logic signed [2*COORD_W+1:0] dq_sq;
            logic signed [COORD_W-1:0]   pt_i;
            logic signed [COORD_W-1:0]   pt_q;

            always_comb
            begin
                pt_i  = cfg.points[k][COORD_W-1:0];
                pt_q  = cfg.points[k][POINT_W-1:COORD_W];
                di    = {s1_i_reg[COORD_W-1], s1_i_reg} - {pt_i[COORD_W-1], pt_i};
                dq    = {s1_q_reg[COORD_W-1], s1_q_reg} - {pt_q[COORD_W-1], pt_q};
                di_sq = di * di;
                dq_sq = dq * dq;
                if (COUNT_W'(k) < cfg.active_count)
                begin
                    dist_next[k] = {1'b0, di_sq[SQ_W-1:0]} + {1'b0, dq_sq[SQ_W-1:0]};
                end
                else
                begin
                    dist_next[k] = DIST_UNUSED;
                end
            end
        end
        else
        begin : g_unused
            assign dist_next[k] = DIST_UNUSED;
        end
    end

    assign dist_out.valid       = s2_valid_reg;
    assign dist_out.frame_start = s2_frame_reg;
    assign dist_out.metric      = s2_dist_reg;

endmodule

// File: rtl/csbp_min_tree.sv
// Registered two-stage minimum search over the point distances and value table lookup.
// Depends on csbp_pkg.
module csbp_min_tree (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  csbp_pkg::dist_stage_t dist_in,
    input  csbp_pkg::cfg_t        cfg,
    output csbp_pkg::sym_stage_t  sym_out
);
    import csbp_pkg::*;

    grp_stage_t            s3_reg;
    grp_stage_t            s3_next;
    sym_stage_t            s4_reg;
    sym_stage_t            s4_next;
    cand_t                 best;

    // Strictly smaller distance replaces; the lower index is always the first argument.
    function automatic cand_t pick(input cand_t a, input cand_t b);
        return (b.metric < a.metric) ? b : a;
    endfunction

    // Each group of four points reduces to one candidate.
    always_comb
    begin
        cand_t c0, c1, c2, c3;
        s3_next.valid       = dist_in.valid;
        s3_next.frame_start = dist_in.frame_start;
        for (int g = 0; g < GROUPS; g++)
        begin
            c0 = '{metric: dist_in.metric[4*g],     idx: IDX_W'(4*g)};
            c1 = '{metric: dist_in.metric[4*g + 1], idx: IDX_W'(4*g + 1)};
            c2 = '{metric: dist_in.metric[4*g + 2], idx: IDX_W'(4*g + 2)};
            c3 = '{metric: dist_in.metric[4*g + 3], idx: IDX_W'(4*g + 3)};
            s3_next.cand[g] = pick(pick(c0, c1), pick(c2, c3));
        end
    end

    // Group winners reduce to the nearest point, whose value is looked up.
    always_comb
    begin
        best = pick(pick(cand_t'(s3_reg.cand[0]), cand_t'(s3_reg.cand[1])),
                    pick(cand_t'(s3_reg.cand[2]), cand_t'(s3_reg.cand[3])));
        s4_next.valid       = s3_reg.valid;
        s4_next.frame_start = s3_reg.frame_start;
        s4_next.value       = cfg.value_table[VAL_W*best.idx +: VAL_W] & value_mask(cfg.nbits);
    end

    // Stage registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_reg <= '0;
            s4_reg <= '0;
        end
        else if (advance)
        begin
            s3_reg <= s3_next;
            s4_reg <= s4_next;
        end
    end

    assign sym_out = s4_reg;

endmodule

// File: rtl/csbp_packer.sv
// LSB-first bit packer with spill-over residue and the output byte register.
// Depends on csbp_pkg and the csbp_byte_if interface.
module csbp_packer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  csbp_pkg::sym_stage_t          sym_in,
    input  logic [csbp_pkg::NBITS_W-1:0]  nbits,
    csbp_byte_if.source                   bytes,
    output logic                          advance
);
    import csbp_pkg::*;

    logic [OFF_W-1:0]     off_reg;
    logic [OFF_W-1:0]     off_next;
    logic [BYTE_W-1:0]    part_reg;
    logic [BYTE_W-1:0]    part_next;
    logic [VAL_W-1:0]     res_bits_reg;
    logic [VAL_W-1:0]     res_bits_next;
    logic [RES_CNT_W-1:0] res_cnt_reg;
    logic [RES_CNT_W-1:0] res_cnt_next;
    logic                 out_valid_reg;
    logic [BYTE_W-1:0]    out_byte_reg;
    logic                 emit;
    logic [BYTE_W-1:0]    emit_byte;

    // The pipeline moves whenever the output register is free or being drained.
    assign advance = !out_valid_reg || bytes.ready;

    // Next packer state for the item in the last stage.
    always_comb
    begin
        logic [OFF_W-1:0]  off1;
        logic [OFF_W-1:0]  off2;
        logic [OFF_W-1:0]  room;
        logic [BYTE_W-1:0] part1;
        logic [BYTE_W-1:0] part2;
        logic [BYTE_W+VAL_W-1:0] shifted;
        logic [VAL_W-1:0]  low_bits;

        off_next      = off_reg;
        part_next     = part_reg;
        res_bits_next = res_bits_reg;
        res_cnt_next  = res_cnt_reg;
        emit          = 1'b0;
        emit_byte     = part_reg;
        off1          = off_reg;
        off2          = off_reg;
        room          = '0;
        part1         = part_reg;
        part2         = part_reg;
        shifted       = '0;
        low_bits      = '0;

        if (sym_in.valid)
        begin
            if (sym_in.frame_start)
            begin
                off_next  = '0;
                part_next = '0;
            end
            else
            begin
                // A pending residue goes in first.
                if (res_cnt_reg != '0)
                begin
                    part1         = part_reg | {{(BYTE_W-VAL_W){1'b0}}, res_bits_reg};
                    off1          = off_reg + {1'b0, res_cnt_reg};
                    res_cnt_next  = '0;
                    res_bits_next = '0;
                end
                if (off1 > OFFSET_FULL)
                begin
                    off1 = OFFSET_FULL;
                end
                room = OFFSET_FULL - off1;

                // Place the symbol's bits; what does not fit spills over.
                if (room >= {1'b0, nbits})
                begin
                    shifted = {{BYTE_W{1'b0}}, sym_in.value} << off1;
                    part2   = part1 | shifted[BYTE_W-1:0];
                    off2    = off1 + {1'b0, nbits};
                end
                else
                begin
                    low_bits      = sym_in.value & ((VAL_W'(1) << room[1:0]) - VAL_W'(1));
                    shifted       = {{BYTE_W{1'b0}}, low_bits} << off1;
                    part2         = part1 | shifted[BYTE_W-1:0];
                    res_cnt_next  = nbits - room[RES_CNT_W-1:0];
                    res_bits_next = sym_in.value >> room[1:0];
                    off2          = OFFSET_FULL;
                end

                // A full byte is released and the packer starts over.
                if (off2 == OFFSET_FULL)
                begin
                    emit      = 1'b1;
                    emit_byte = part2;
                    off_next  = '0;
                    part_next = '0;
                end
                else
                begin
                    off_next  = off2;
                    part_next = part2;
                end
            end
        end
    end

    // Packer state and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg       <= '0;
            part_reg      <= '0;
            res_bits_reg  <= '0;
            res_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            off_reg       <= off_next;
            part_reg      <= part_next;
            res_bits_reg  <= res_bits_next;
            res_cnt_reg   <= res_cnt_next;
            out_valid_reg <= emit;
        end
    end

    // Output byte payload.
    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_byte_reg <= emit_byte;
        end
    end

    assign bytes.valid     = out_valid_reg;
    assign bytes.data_byte = out_byte_reg;

endmodule

// File: rtl/constellation_slicer_bit_packer_top.sv
// Top level of the constellation slicer and bit packer.
// Depends on csbp_pkg, the channel interfaces and all csbp_* modules.
//
// The block takes one symbol or frame-start request per clock cycle and keeps that rate for
// as long as the byte channel drains. A symbol passes an input register, a stage of parallel
// squared-distance lanes (one per point), two registered stages of the nearest-point search
// with the value lookup, and the packer, which loads the output byte register. All stages
// advance together and hold only while a finished byte waits in the output register, so
// symbols wait behind a byte that the byte channel has not yet taken. Configuration writes
// take effect at once; the user must make them while no symbol is in flight, as the block
// itself does not enforce this. There is no clearing pass after reset.
module constellation_slicer_bit_packer_top #(
    parameter int MAX_POINTS = csbp_pkg::DEFAULT_MAX_POINTS
) (
    input  logic         clk,
    input  logic         rst_n,
    csbp_sym_if.sink     symbols,
    csbp_byte_if.source  bytes,
    csbp_cfg_if.sink     cfg
);
    import csbp_pkg::*;

    cfg_t        cfg_view;
    dist_stage_t dist_stage;
    sym_stage_t  sym_stage;
    logic        advance;

    assign symbols.ready = advance;

    // Configuration registers.
    csbp_cfg_regs #(
        .MaxPoints (MAX_POINTS)
    ) u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_view)
    );

    // Input register and distance lanes.
    csbp_dist #(
        .MaxPoints (MAX_POINTS)
    ) u_dist (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .in_valid       (symbols.valid),
        .in_frame_start (symbols.frame_start),
        .in_sym_i       (symbols.sym_i),
        .in_sym_q       (symbols.sym_q),
        .cfg            (cfg_view),
        .dist_out       (dist_stage)
    );

    // Nearest-point search and value lookup.
    csbp_min_tree u_min_tree (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .dist_in (dist_stage),
        .cfg     (cfg_view),
        .sym_out (sym_stage)
    );

    // Bit packer and output register.
    csbp_packer u_packer (
        .clk     (clk),
        .rst_n   (rst_n),
        .sym_in  (sym_stage),
        .nbits   (cfg_view.nbits),
        .bytes   (bytes),
        .advance (advance)
    );

endmodule
